>>> rtl/core/snc_pkg.sv
// Shared constants, types and SHA-256 and double-dabble helper functions for the nonce checker.
// Depends on nothing; imported by every module under rtl/core.
package snc_pkg;

    localparam int MAX_PREFIX_BYTES = 32;
    localparam int NUM_DIGITS       = 20;
    localparam int BCD_STAGES       = 32;   // two binary bits per stage
    localparam int ROUNDS           = 64;

    // Configuration register indexes
    localparam logic [2:0] CFG_PREFIX_0   = 3'd0;
    localparam logic [2:0] CFG_PREFIX_1   = 3'd1;
    localparam logic [2:0] CFG_PREFIX_2   = 3'd2;
    localparam logic [2:0] CFG_PREFIX_3   = 3'd3;
    localparam logic [2:0] CFG_PREFIX_LEN = 3'd4;
    localparam logic [2:0] CFG_TARGET     = 3'd5;

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // One transaction between front and back: nonce plus padded block
    typedef struct packed {
        logic [63:0]  nonce;
        logic [511:0] blk;     // byte p at [511-8p -: 8]
    } snc_item_t;

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

    // One double-dabble step: add 3 to digits of 5 or more, shift in one bit
    function automatic logic [79:0] dabble(input logic [79:0] bcd, input logic b);
        logic [79:0] t;
        t = bcd;
        for (int j = 0; j < NUM_DIGITS; j++)
        begin
            if (t[4*j +: 4] >= 4'd5)
            begin
                t[4*j +: 4] = t[4*j +: 4] + 4'd3;
            end
        end
        return {t[78:0], b};
    endfunction

endpackage

>>> rtl/core/sha256_nonce_target_check.sv
// Top level: configuration registers, front end, queue and hash back end.
// Depends on snc_pkg, snc_front, snc_fifo and snc_back.

// Accepts one candidate nonce per clock while in_stall is low and returns
// one result per nonce, in order. A nonce passes through the decimal
// conversion and message build (32 double-dabble stages of two bits each,
// plus two assembly stages), the two-entry queue, the unrolled SHA-256
// round pipeline and the output register. Each side stalls independently;
// the queue absorbs the difference. Configuration writes are always
// accepted and should be made while no nonce is in flight.
module sha256_nonce_target_check
    import snc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] candidate,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic [63:0] nonce_echo,
    output logic [47:0] hash_head,
    output logic [63:0] digest_word_0,
    output logic [63:0] digest_word_1,
    output logic [63:0] digest_word_2,
    output logic [63:0] digest_word_3
);

    logic [255:0] prefix_reg;
    logic [5:0]   plen_reg;
    logic [47:0]  target_reg;

    logic         push, full, pop, nonempty;
    snc_item_t    push_item, pop_item;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= '0;
            plen_reg   <= '0;
            target_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PREFIX_0:   prefix_reg[255:192] <= cfg_data;
                CFG_PREFIX_1:   prefix_reg[191:128] <= cfg_data;
                CFG_PREFIX_2:   prefix_reg[127:64]  <= cfg_data;
                CFG_PREFIX_3:   prefix_reg[63:0]    <= cfg_data;
                CFG_PREFIX_LEN: plen_reg            <= cfg_data[5:0];
                CFG_TARGET:     target_reg          <= cfg_data[47:0];
                default:        ;
            endcase
        end
    end

    snc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .candidate   (candidate),
        .prefix      (prefix_reg),
        .prefix_size (plen_reg),
        .full        (full),
        .push        (push),
        .push_item   (push_item)
    );

    snc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .nonempty  (nonempty),
        .pop_item  (pop_item)
    );

    snc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .nonempty      (nonempty),
        .pop_item      (pop_item),
        .pop           (pop),
        .target        (target_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .nonce_echo    (nonce_echo),
        .hash_head     (hash_head),
        .digest_word_0 (digest_word_0),
        .digest_word_1 (digest_word_1),
        .digest_word_2 (digest_word_2),
        .digest_word_3 (digest_word_3)
    );

endmodule

>>> rtl/core/snc_fifo.sv
// Two-entry queue that decouples message build from the hash rounds.
// Depends on snc_pkg for the transaction type.
module snc_fifo
    import snc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  snc_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      nonempty,
    output snc_item_t pop_item
);

    snc_item_t   mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign nonempty = (count_reg != 2'd0);
    assign pop_item = mem[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/core/snc_front.sv
// Front end: binary-to-decimal pipeline and padded message block assembly.
// Depends on snc_pkg; feeds snc_fifo.
module snc_front
    import snc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [63:0]  candidate,
    input  logic [255:0] prefix,
    input  logic [5:0]   prefix_size,
    input  logic         full,
    output logic         push,
    output snc_item_t    push_item
);

    logic        v_reg   [0:BCD_STAGES];
    logic [63:0] bin_reg [0:BCD_STAGES];
    logic [79:0] bcd_reg [0:BCD_STAGES];
    logic [63:0] non_reg [0:BCD_STAGES];

    logic             va_reg;
    logic [4:0]       nd_reg;
    logic [19:0][7:0] left_reg;
    logic [63:0]      nona_reg;

    logic             vb_reg;
    snc_item_t        item_reg;

    logic             en;
    logic [4:0]       nd_next;
    logic [19:0][7:0] left_next;
    logic [4:0]       di;
    logic [5:0]       plen;
    logic [5:0]       k;
    logic [5:0]       msg_len;
    logic [511:0]     blk_next;

    // whole front advances together unless its last stage is blocked
    assign en        = !vb_reg || !full;
    assign in_stall  = !en;
    assign push      = vb_reg && !full;
    assign push_item = item_reg;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= BCD_STAGES; s++)
            begin
                v_reg[s] <= 1'b0;
            end
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= BCD_STAGES; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
            va_reg <= v_reg[BCD_STAGES];
            vb_reg <= va_reg;
        end
    end

    // double dabble, two bits per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bin_reg[0] <= candidate;
            bcd_reg[0] <= '0;
            non_reg[0] <= candidate;
            for (int s = 1; s <= BCD_STAGES; s++)
            begin
                bin_reg[s] <= {bin_reg[s-1][61:0], 2'b00};
                bcd_reg[s] <= dabble(dabble(bcd_reg[s-1], bin_reg[s-1][63]),
                                     bin_reg[s-1][62]);
                non_reg[s] <= non_reg[s-1];
            end
        end
    end

    // digit count and left-aligned ASCII digits
    always_comb
    begin
        nd_next = 5'd1;
        for (int j = 0; j < NUM_DIGITS; j++)
        begin
            if (bcd_reg[BCD_STAGES][4*j +: 4] != 4'd0)
            begin
                nd_next = 5'(j + 1);
            end
        end
        left_next = '0;
        di        = '0;
        for (int j = 0; j < NUM_DIGITS; j++)
        begin
            if (5'(j) < nd_next)
            begin
                di = nd_next - 5'd1 - 5'(j);
                left_next[j] = {4'h3, bcd_reg[BCD_STAGES][4*di +: 4]};
            end
        end
    end

    // place prefix, digits, pad byte and bit length
    always_comb
    begin
        plen     = (prefix_size > 6'(MAX_PREFIX_BYTES)) ? 6'(MAX_PREFIX_BYTES) : prefix_size;
        blk_next = '0;
        k        = '0;
        for (int p = 0; p < 32; p++)
        begin
            if (6'(p) < plen)
            begin
                blk_next[511-8*p -: 8] = prefix[255-8*p -: 8];
            end
        end
        for (int p = 0; p < 56; p++)
        begin
            if (6'(p) >= plen)
            begin
                k = 6'(p) - plen;
                if (k < {1'b0, nd_reg})
                begin
                    blk_next[511-8*p -: 8] = left_reg[k[4:0]];
                end
                else if (k == {1'b0, nd_reg})
                begin
                    blk_next[511-8*p -: 8] = 8'h80;
                end
            end
        end
        msg_len         = plen + {1'b0, nd_reg};
        blk_next[63:0]  = {55'd0, msg_len, 3'b000};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nd_reg         <= nd_next;
            left_reg       <= left_next;
            nona_reg       <= non_reg[BCD_STAGES];
            item_reg.nonce <= nona_reg;
            item_reg.blk   <= blk_next;
        end
    end

endmodule

>>> rtl/core/snc_back.sv
// Back end: 64-stage SHA-256 round pipeline, digest add and target compare.
// Depends on snc_pkg; drains snc_fifo and drives the result port.
module snc_back
    import snc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        nonempty,
    input  snc_item_t   pop_item,
    output logic        pop,
    input  logic [47:0] target,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic [63:0] nonce_echo,
    output logic [47:0] hash_head,
    output logic [63:0] digest_word_0,
    output logic [63:0] digest_word_1,
    output logic [63:0] digest_word_2,
    output logic [63:0] digest_word_3
);

    logic              v_reg   [0:ROUNDS];
    logic [7:0][31:0]  st_reg  [0:ROUNDS];
    logic [15:0][31:0] win_reg [0:ROUNDS];
    logic [63:0]       non_reg [0:ROUNDS];
    logic [7:0][31:0]  st_next  [ROUNDS];
    logic [15:0][31:0] win_next [ROUNDS];
    logic [15:0][31:0] win_load;

    logic              out_valid_reg;
    logic              hit_reg;
    logic [63:0]       nonce_reg;
    logic [47:0]       head_reg;
    logic [7:0][31:0]  dig_reg;
    logic [7:0][31:0]  dig_next;
    logic [47:0]       head_next;

    logic en;

    assign en  = !out_valid_reg || !out_stall;
    assign pop = nonempty && en;

    // message words from the block
    always_comb
    begin
        for (int j = 0; j < 16; j++)
        begin
            win_load[j] = pop_item.blk[511-32*j -: 32];
        end
    end

    // round logic, one round per stage
    for (genvar r = 0; r < ROUNDS; r++)
    begin : g_round
        logic [31:0] t1, t2;
        always_comb
        begin
            t1 = st_reg[r][7] + bsig1(st_reg[r][4])
               + ((st_reg[r][4] & st_reg[r][5]) ^ (~st_reg[r][4] & st_reg[r][6]))
               + K_ROUND[r] + win_reg[r][0];
            t2 = bsig0(st_reg[r][0])
               + ((st_reg[r][0] & st_reg[r][1]) ^ (st_reg[r][0] & st_reg[r][2])
                  ^ (st_reg[r][1] & st_reg[r][2]));
            st_next[r][0] = t1 + t2;
            st_next[r][1] = st_reg[r][0];
            st_next[r][2] = st_reg[r][1];
            st_next[r][3] = st_reg[r][2];
            st_next[r][4] = st_reg[r][3] + t1;
            st_next[r][5] = st_reg[r][4];
            st_next[r][6] = st_reg[r][5];
            st_next[r][7] = st_reg[r][6];
            for (int j = 0; j < 15; j++)
            begin
                win_next[r][j] = win_reg[r][j+1];
            end
            win_next[r][15] = ssig1(win_reg[r][14]) + win_reg[r][9]
                            + ssig0(win_reg[r][1]) + win_reg[r][0];
        end
    end

    // final digest and its leading 48 bits
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            dig_next[i] = st_reg[ROUNDS][i] + H_INIT[i];
        end
        head_next = {dig_next[0], dig_next[1][31:16]};
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= ROUNDS; s++)
            begin
                v_reg[s] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= nonempty;
            for (int s = 1; s <= ROUNDS; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
            out_valid_reg <= v_reg[ROUNDS];
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 8; i++)
            begin
                st_reg[0][i] <= H_INIT[i];
            end
            win_reg[0] <= win_load;
            non_reg[0] <= pop_item.nonce;
            for (int s = 1; s <= ROUNDS; s++)
            begin
                st_reg[s]  <= st_next[s-1];
                win_reg[s] <= win_next[s-1];
                non_reg[s] <= non_reg[s-1];
            end
            dig_reg   <= dig_next;
            head_reg  <= head_next;
            hit_reg   <= (head_next <= target);
            nonce_reg <= non_reg[ROUNDS];
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign nonce_echo    = nonce_reg;
    assign hash_head     = head_reg;
    assign digest_word_0 = {dig_reg[0], dig_reg[1]};
    assign digest_word_1 = {dig_reg[2], dig_reg[3]};
    assign digest_word_2 = {dig_reg[4], dig_reg[5]};
    assign digest_word_3 = {dig_reg[6], dig_reg[7]};

endmodule
